// File: rtl/core/scaled_text_scanline_renderer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scanline renderer
// Macros for the concurrent checks in the renderer RTL.
// ----------------------------------------------------------------------------
`ifndef SCALED_TEXT_SCANLINE_RENDERER_UNIT_ASSERT_SVH
`define SCALED_TEXT_SCANLINE_RENDERER_UNIT_ASSERT_SVH

// Check on every clock edge outside reset.
`define STSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define STSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/stsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline renderer package
// Sizes, types, font ROM and pixel helpers for the text scanline renderer.
// ----------------------------------------------------------------------------
package stsr_pkg;

  localparam int SCALE       = 2;
  localparam int ROW_BYTES   = 25;
  localparam int MAX_CHARS   = 32;
  localparam int GLYPH_COUNT = 23;
  localparam int ROM_GLYPHS  = 23;

  localparam int K_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int CH_W  = 7;
  localparam int LEN_W = 6;
  localparam int AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int BP_W  = (SCALE > 1) ? $clog2(SCALE) : 1;

  localparam int PIX_PER_BYTE = 8 / SCALE;
  localparam int FILL         = (1 << SCALE) - 1;

  typedef logic [K_W-1:0]   k_t;
  typedef logic [CH_W-1:0]  ch_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [AW-1:0]    addr_t;
  typedef logic [BP_W-1:0]  bp_t;

  typedef enum logic {
    ST_IDLE,
    ST_RENDER
  } state_t;

  // input item kinds, carried on in_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [7:0] GLYPH_CODES [ROM_GLYPHS] = '{
    8'h20, 8'h25, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h3A, 8'h43, 8'h49, 8'h4E, 8'h4F, 8'h50, 8'h54, 8'h55, 8'h61, 8'hB0
  };

  localparam logic [7:0] GLYPH_ROM [ROM_GLYPHS][8] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'hc6, 8'hcc, 8'h18, 8'h30, 8'h66, 8'hc6, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h30, 8'h00},
    '{8'h7c, 8'hc6, 8'hce, 8'hde, 8'hf6, 8'he6, 8'h7c, 8'h00},
    '{8'h30, 8'h70, 8'h30, 8'h30, 8'h30, 8'h30, 8'hfc, 8'h00},
    '{8'h78, 8'hcc, 8'h0c, 8'h38, 8'h60, 8'hcc, 8'hfc, 8'h00},
    '{8'h78, 8'hcc, 8'h0c, 8'h38, 8'h0c, 8'hcc, 8'h78, 8'h00},
    '{8'h1c, 8'h3c, 8'h6c, 8'hcc, 8'hfe, 8'h0c, 8'h1e, 8'h00},
    '{8'hfc, 8'hc0, 8'hf8, 8'h0c, 8'h0c, 8'hcc, 8'h78, 8'h00},
    '{8'h38, 8'h60, 8'hc0, 8'hf8, 8'hcc, 8'hcc, 8'h78, 8'h00},
    '{8'hfc, 8'hcc, 8'h0c, 8'h18, 8'h30, 8'h30, 8'h30, 8'h00},
    '{8'h78, 8'hcc, 8'hcc, 8'h78, 8'hcc, 8'hcc, 8'h78, 8'h00},
    '{8'h78, 8'hcc, 8'hcc, 8'h7c, 8'h0c, 8'h18, 8'h70, 8'h00},
    '{8'h00, 8'h30, 8'h30, 8'h00, 8'h00, 8'h30, 8'h30, 8'h00},
    '{8'h3c, 8'h66, 8'hc0, 8'hc0, 8'hc0, 8'h66, 8'h3c, 8'h00},
    '{8'h78, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h78, 8'h00},
    '{8'hc6, 8'he6, 8'hf6, 8'hde, 8'hce, 8'hc6, 8'hc6, 8'h00},
    '{8'h38, 8'h6c, 8'hc6, 8'hc6, 8'hc6, 8'h6c, 8'h38, 8'h00},
    '{8'hfc, 8'h66, 8'h66, 8'h7c, 8'h60, 8'h60, 8'hf0, 8'h00},
    '{8'hfc, 8'hb4, 8'h30, 8'h30, 8'h30, 8'h30, 8'h78, 8'h00},
    '{8'hcc, 8'hcc, 8'hcc, 8'hcc, 8'hcc, 8'hcc, 8'hfc, 8'h00},
    '{8'h00, 8'h00, 8'h78, 8'h0c, 8'h7c, 8'hcc, 8'h76, 8'h00},
    '{8'h04, 8'h0A, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // glyph row index = scanline / SCALE, as a threshold table
  function automatic logic [3:0] scan_row(input logic [3:0] scan);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (int'(scan) >= i * SCALE) r = 4'(i);
    end
    return r;
  endfunction

  // font row for a code; blank for unmapped codes and rows past seven
  function automatic logic [7:0] glyph_row(input logic [7:0] code, input logic [3:0] row);
    logic [7:0] px;
    px = 8'h00;
    if (row < 4'd8) begin
      for (int g = 0; g < ROM_GLYPHS; g++) begin
        if (g < GLYPH_COUNT && GLYPH_CODES[g] == code) px = GLYPH_ROM[g][row[2:0]];
      end
    end
    return px;
  endfunction

  // one output byte of a row widened SCALE times; part picks the byte
  function automatic logic [7:0] widen(input logic [7:0] row, input bp_t part);
    int src;
    int outv;
    outv = 0;
    for (int b = 0; b < PIX_PER_BYTE; b++) begin
      src = int'(part) * PIX_PER_BYTE + b;
      if (src < 8) begin
        if (row[7 - src]) outv = outv | (FILL << (8 - SCALE * (b + 1)));
      end
    end
    return outv[7:0];
  endfunction

endpackage

// File: rtl/core/stsr_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line buffer
// Character code store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stsr_line_buf (
  input  logic               clk,
  input  logic               wr_en,
  input  stsr_pkg::addr_t    wr_addr,
  input  logic [7:0]         wr_data,
  input  logic               rd_en,
  input  stsr_pkg::addr_t    rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem_r [stsr_pkg::MAX_CHARS];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/scaled_text_scanline_renderer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled text scanline renderer
// Character generator that turns a stored text line into scaled pixel bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel takes one word per item. in_tuser is the kind: write (store
//   char_code at char_pos, in_tlast = end of text sets the line length) or
//   render (emit one scanline). A write finishes in the accept cycle.
//   A render emits ROW_BYTES words on out_*, one per cycle while out_tready
//   is high: left_margin blank bytes, SCALE bytes per character, blank bytes
//   after the text. out_tlast marks the final byte of the scanline.
//   Pipeline: issue, line buffer read, output register. A render holds off
//   the input side while the byte sequencer steps through its bytes, with a
//   buffer read for character bytes only; the next item is taken right
//   after the last byte is issued.
//   Stall: a low out_tready with out_tvalid high freezes the sequencer, the
//   read stage and the output register together; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous): sequencer idle, line length zero, margin
//   zero, output empty. Buffer contents are not cleared.
//   cfg_we writes left_margin; write it only while the block is idle.
// ----------------------------------------------------------------------------
`include "scaled_text_scanline_renderer_unit_assert.svh"

module scaled_text_scanline_renderer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,   // left_margin
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [4:0] char_pos, [12:5] char_code, [16:13] scanline
  input  logic        in_tuser,    // op
  input  logic        in_tlast,    // end_of_text
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] pixel_byte
  output logic        out_tlast    // last
);

  // --------------------------------------------------------------------------
  // Input unpack
  // --------------------------------------------------------------------------
  logic [4:0] in_pos;
  logic [7:0] in_code;
  logic [3:0] in_scan;

  assign in_pos  = in_tdata[4:0];
  assign in_code = in_tdata[12:5];
  assign in_scan = in_tdata[16:13];

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  stsr_pkg::state_t state_r, state_nxt;
  stsr_pkg::k_t     k_r, k_nxt;          // byte index within the scanline
  stsr_pkg::ch_t    ch_r, ch_nxt;        // character index
  stsr_pkg::bp_t    bp_r, bp_nxt;        // byte within the current character
  logic [3:0]       row_r, row_nxt;      // glyph row of the current render
  stsr_pkg::len_t   len_r, len_nxt;      // text length
  logic [4:0]       margin_r;

  // read stage
  logic             b_vld_r;
  logic             b_show_r;
  stsr_pkg::bp_t    b_bp_r;
  logic [3:0]       b_row_r;
  logic             b_last_r;

  // output register
  logic             out_vld_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;

  logic             in_acc;
  logic             adv;       // whole pipe moves this cycle
  logic             issue;
  logic             in_margin;
  logic             show;
  logic             wr_en;
  logic [7:0]       rd_data;
  logic [7:0]       pix;

  assign in_tready = (state_r == stsr_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign adv       = !out_vld_r || out_tready;
  assign issue     = (state_r == stsr_pkg::ST_RENDER) && adv;

  assign in_margin = stsr_pkg::ch_t'(k_r) < stsr_pkg::ch_t'(margin_r);
  assign show      = !in_margin
                     && (ch_r < stsr_pkg::ch_t'(len_r))
                     && (ch_r < stsr_pkg::ch_t'(stsr_pkg::MAX_CHARS));

  // out-of-range writes are dropped, end of text included
  assign wr_en = in_acc && (in_tuser == stsr_pkg::OP_WRITE)
                 && (stsr_pkg::ch_t'(in_pos) < stsr_pkg::ch_t'(stsr_pkg::MAX_CHARS));

  // --------------------------------------------------------------------------
  // Line buffer
  // --------------------------------------------------------------------------
  stsr_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stsr_pkg::addr_t'(in_pos)),
    .wr_data (in_code),
    .rd_en   (issue && show),
    .rd_addr (stsr_pkg::addr_t'(ch_r)),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ch_nxt    = ch_r;
    bp_nxt    = bp_r;
    row_nxt   = row_r;
    len_nxt   = len_r;
    unique case (state_r)
      stsr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == stsr_pkg::OP_RENDER) begin
            state_nxt = stsr_pkg::ST_RENDER;
            k_nxt     = '0;
            ch_nxt    = '0;
            bp_nxt    = '0;
            row_nxt   = stsr_pkg::scan_row(in_scan);
          end else if (wr_en && in_tlast) begin
            len_nxt = stsr_pkg::len_t'(stsr_pkg::ch_t'(in_pos) + stsr_pkg::ch_t'(1));
          end
        end
      end
      stsr_pkg::ST_RENDER: begin
        if (issue) begin
          if (!in_margin) begin
            if (int'(bp_r) == stsr_pkg::SCALE - 1) begin
              bp_nxt = '0;
              ch_nxt = ch_r + stsr_pkg::ch_t'(1);
            end else begin
              bp_nxt = bp_r + stsr_pkg::bp_t'(1);
            end
          end
          if (int'(k_r) == stsr_pkg::ROW_BYTES - 1) begin
            state_nxt = stsr_pkg::ST_IDLE;
            k_nxt     = '0;
            ch_nxt    = '0;
            bp_nxt    = '0;
          end else begin
            k_nxt = k_r + stsr_pkg::k_t'(1);
          end
        end
      end
      default: state_nxt = stsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= stsr_pkg::ST_IDLE;
      k_r      <= '0;
      ch_r     <= '0;
      bp_r     <= '0;
      len_r    <= '0;
      margin_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ch_r    <= ch_nxt;
      bp_r    <= bp_nxt;
      len_r   <= len_nxt;
      if (cfg_we) begin
        margin_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  // --------------------------------------------------------------------------
  // Read stage and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_show_r <= show;
      b_bp_r   <= bp_r;
      b_row_r  <= row_r;
      b_last_r <= (int'(k_r) == stsr_pkg::ROW_BYTES - 1);
    end
  end

  assign pix = b_show_r ? stsr_pkg::widen(stsr_pkg::glyph_row(rd_data, b_row_r), b_bp_r)
                        : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= pix;
      out_last_r <= b_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `STSR_ASSERT(a_k_range, int'(k_r) < stsr_pkg::ROW_BYTES, "byte index past row end")
  `STSR_ASSERT(a_bp_range, int'(bp_r) < stsr_pkg::SCALE, "byte-in-char past scale")
  `STSR_ASSERT(a_render_start, (in_acc && in_tuser == stsr_pkg::OP_RENDER) |=> (state_r == stsr_pkg::ST_RENDER && k_r == '0), "render did not start at byte zero")
  `STSR_ASSERT(a_read_hold, (b_vld_r && !adv) |=> (b_vld_r && $stable(rd_data)), "read data lost under stall")
  `STSR_ASSERT(a_idle_clear, (state_r == stsr_pkg::ST_IDLE) |-> (ch_r == '0 && bp_r == '0), "char counters not cleared in idle")

endmodule
